FILE: design/topic_pattern_router_table_top_macros.svh
// ----------------------------------------------------------------------------
// Topic router assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOPIC_PATTERN_ROUTER_TABLE_TOP_MACROS_SVH
`define TOPIC_PATTERN_ROUTER_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("topic router assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPRT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("topic router assertion failed");

`endif

FILE: design/tprt_pkg.sv
// ----------------------------------------------------------------------------
// Topic router package
// Sizes, character codes, command and result beats, and internal types.
// ----------------------------------------------------------------------------
package tprt_pkg;

	localparam int MAX_BINDINGS   = 16;
	localparam int MAX_STRING_LEN = 64;
	localparam int RESULT_LIMIT   = 16;

	localparam int SLOT_W  = $clog2(MAX_BINDINGS);
	localparam int CNT_W   = $clog2(MAX_BINDINGS + 1);
	localparam int OFF_W   = $clog2(MAX_STRING_LEN);
	localparam int LEN_W   = $clog2(MAX_STRING_LEN + 1);
	localparam int PADDR_W = SLOT_W + OFF_W;
	localparam int TGT_W   = 16;
	localparam int MAXT_W  = 5;

	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_STAR = 8'h2A;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_LONG = 2'd3;

	typedef enum logic [1:0] {
		MODE_BIND,
		MODE_UNBIND,
		MODE_ROUTE,
		MODE_QUERY
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENTRY,
		ST_EQ_RD,
		ST_EQ_EV,
		ST_MT_RD,
		ST_MT_EV,
		ST_SEG,
		ST_CPY_RD,
		ST_CPY_WR,
		ST_FLUSH
	} tprt_state_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_SET_TGT,
		DIR_APPEND,
		DIR_REMOVE
	} dir_op_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [7:0]        string_byte;
		logic [TGT_W-1:0]  bind_target;
		logic [MAXT_W-1:0] target_limit;
	} tprt_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [TGT_W-1:0] result_target;
		logic             last_result;
	} tprt_out_t;

	typedef struct packed {
		dir_op_t          op;
		logic [CNT_W-1:0] idx;
		logic [LEN_W-1:0] plen;
		logic [TGT_W-1:0] ptgt;
	} dir_cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  plen;
		logic [TGT_W-1:0]  ptgt;
		logic [CNT_W-1:0]  count;
	} dir_stat_t;

endpackage

FILE: design/topic_pattern_router_table_top.sv
// ----------------------------------------------------------------------------
// Topic pattern router table
// Binds, unbinds, queries and routes dot-separated topics against patterns.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat
//  request   in         start high, busy low      req   (tprt_in_t)
//  result    out        strobe, one cycle, no hold rsp  (tprt_out_t)
//
//  A non-zero byte is stored without leaving idle, so busy stays low.
//  An ending byte walks the table one entry at a time: each byte compared
//  passes a read and an evaluate state on the pattern and string RAM ports,
//  plus a state per entry and per segment; a new bind then copies each byte.
//  Reset clears the count, the string length and the control; no sweep.
//  Results cannot be stalled; busy is low by the time the last result beat appears.
// ----------------------------------------------------------------------------
`include "topic_pattern_router_table_top_macros.svh"

module topic_pattern_router_table_top import tprt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  tprt_in_t  req,
	output logic      strobe,
	output tprt_out_t rsp
);

	tprt_state_t state_q, state_d;

	mode_t             mode_q, mode_d;
	logic [TGT_W-1:0]  tgt_q, tgt_d;
	logic [MAXT_W-1:0] maxt_q, maxt_d, maxt_c, n_q, n_d;
	logic [LEN_W-1:0]  tl_q, tl_d, len_q, len_d;
	logic [LEN_W-1:0]  k_q, k_d, pi_q, pi_d, ti_q, ti_d, sp_q, sp_d, st_q, st_d;
	logic [CNT_W-1:0]  e_q, e_d;
	logic              pdone_q, pdone_d, tdone_q, tdone_d, eq_q, eq_d, tfin_q, tfin_d;
	logic              pv_q, pv_d, tv_q, tv_d;
	logic [7:0]        first_q, first_d;
	logic              pend_v_q, pend_v_d, hit_q, hit_d, toolong_q, toolong_d;
	logic [TGT_W-1:0]  pend_tgt_q, pend_tgt_d;
	logic              strobe_q;
	tprt_out_t         rsp_q, emit_rsp;
	logic              emit;

	dir_cmd_t  dir_cmd;
	dir_stat_t dir_stat;

	logic               buf_we, pat_we;
	logic [OFF_W-1:0]   buf_raddr;
	logic [7:0]         buf_rdata, pat_rdata;
	logic [PADDR_W-1:0] pat_raddr, pat_waddr;

	logic             acc, acc_end;
	logic [LEN_W:0]   ppos, tpos, pseg_end, tseg_end;
	logic             pv_now, tv_now, pdone_n, tdone_n;
	logic             pend, tend, phash, pstar, seg_done, seg_val, seg_tfin;
	logic             ev_end, ev_no, ev_yes, route_full;
	tprt_state_t      after_yes;

	tprt_ram #(.ADDR_W(OFF_W), .DATA_W(8)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (len_q[OFF_W-1:0]),
		.wdata (req.string_byte),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	tprt_ram #(.ADDR_W(PADDR_W), .DATA_W(8)) u_pat (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (buf_rdata),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	tprt_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dir_cmd),
		.stat   (dir_stat)
	);

	assign busy    = (state_q != ST_IDLE);
	assign acc     = start && !busy;
	assign acc_end = acc && (req.string_byte == 8'd0);
	assign maxt_c  = (req.target_limit > MAXT_W'(RESULT_LIMIT)) ?
		MAXT_W'(RESULT_LIMIT) : req.target_limit;

	assign ppos   = {1'b0, pi_q} + {1'b0, k_q};
	assign tpos   = {1'b0, ti_q} + {1'b0, k_q};
	assign pv_now = !pdone_q && (ppos < {1'b0, dir_stat.plen});
	assign tv_now = !tdone_q && !tfin_q && (tpos < {1'b0, tl_q});

	assign buf_raddr = (state_q == ST_MT_RD) ? tpos[OFF_W-1:0] : k_q[OFF_W-1:0];
	assign pat_raddr = {dir_stat.slot,
		(state_q == ST_MT_RD) ? ppos[OFF_W-1:0] : k_q[OFF_W-1:0]};
	assign pat_waddr = {dir_stat.slot, k_q[OFF_W-1:0]};

	// A segment ends at a dot or past the end of its string.
	assign pdone_n = !pv_q || (pat_rdata == CH_DOT);
	assign tdone_n = !tv_q || (buf_rdata == CH_DOT);

	assign pseg_end = {1'b0, pi_q} + {1'b0, sp_q};
	assign tseg_end = {1'b0, ti_q} + {1'b0, st_q};
	assign pend     = pseg_end >= {1'b0, dir_stat.plen};
	assign tend     = tseg_end >= {1'b0, tl_q};
	assign phash    = (sp_q == LEN_W'(1)) && (first_q == CH_HASH);
	assign pstar    = (sp_q == LEN_W'(1)) && (first_q == CH_STAR);

	// Segment verdict. Once the topic has run out, only a final lone hash
	// remaining in the pattern still matches.
	always_comb begin
		seg_done = 1'b1;
		seg_val  = 1'b0;
		seg_tfin = 1'b0;
		if (tfin_q) begin
			seg_val = phash && pend;
		end else if (pend && sp_q == '0 && tend && st_q == '0) begin
			seg_val = 1'b1;
		end else if (phash) begin
			seg_val = pend;
		end else if (tend && st_q == '0) begin
			seg_val = 1'b0;
		end else if (pend && sp_q == '0) begin
			seg_val = 1'b0;
		end else if (!pstar && !(sp_q == st_q && eq_q)) begin
			seg_val = 1'b0;
		end else if (pend && tend) begin
			seg_val = 1'b1;
		end else if (pend) begin
			seg_val = 1'b0;
		end else if (tend) begin
			seg_done = 1'b0;
			seg_tfin = 1'b1;
		end else begin
			seg_done = 1'b0;
		end
	end

	assign ev_end = (state_q == ST_ENTRY) && (e_q >= dir_stat.count);
	assign ev_no  = ((state_q == ST_ENTRY) && !ev_end && mode_q != MODE_ROUTE &&
			dir_stat.plen != tl_q) ||
		((state_q == ST_EQ_EV) && pat_rdata != buf_rdata) ||
		((state_q == ST_SEG) && seg_done && !seg_val);
	assign ev_yes = ((state_q == ST_EQ_RD) && k_q == tl_q) ||
		((state_q == ST_SEG) && seg_done && seg_val);
	assign route_full = (n_q + MAXT_W'(1)) == maxt_q;

	always_comb begin
		unique case (mode_q)
			MODE_BIND, MODE_QUERY: after_yes = ST_IDLE;
			MODE_UNBIND:           after_yes = ST_ENTRY;
			MODE_ROUTE:            after_yes = route_full ? ST_FLUSH : ST_ENTRY;
			default:               after_yes = ST_IDLE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_end && !toolong_q &&
						!(req.mode == MODE_ROUTE && maxt_c == '0)) begin
					state_d = ST_ENTRY;
				end
			end
			ST_ENTRY: begin
				if (ev_end) begin
					state_d = (mode_q == MODE_BIND &&
						dir_stat.count < CNT_W'(MAX_BINDINGS)) ? ST_CPY_RD : ST_IDLE;
				end else if (ev_no) begin
					state_d = ST_ENTRY;
				end else begin
					state_d = (mode_q == MODE_ROUTE) ? ST_MT_RD : ST_EQ_RD;
				end
			end
			ST_EQ_RD:  state_d = ev_yes ? after_yes : ST_EQ_EV;
			ST_EQ_EV:  state_d = ev_no ? ST_ENTRY : ST_EQ_RD;
			ST_MT_RD:  state_d = ST_MT_EV;
			ST_MT_EV:  state_d = (pdone_n && tdone_n) ? ST_SEG : ST_MT_RD;
			ST_SEG: begin
				if (!seg_done) begin
					state_d = ST_MT_RD;
				end else begin
					state_d = seg_val ? after_yes : ST_ENTRY;
				end
			end
			ST_CPY_RD: state_d = (k_q == tl_q) ? ST_IDLE : ST_CPY_WR;
			ST_CPY_WR: state_d = ST_CPY_RD;
			ST_FLUSH:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mode_d     = mode_q;
		tgt_d      = tgt_q;
		maxt_d     = maxt_q;
		n_d        = n_q;
		tl_d       = tl_q;
		len_d      = len_q;
		k_d        = k_q;
		pi_d       = pi_q;
		ti_d       = ti_q;
		sp_d       = sp_q;
		st_d       = st_q;
		e_d        = e_q;
		pdone_d    = pdone_q;
		tdone_d    = tdone_q;
		eq_d       = eq_q;
		tfin_d     = tfin_q;
		pv_d       = pv_q;
		tv_d       = tv_q;
		first_d    = first_q;
		pend_v_d   = pend_v_q;
		pend_tgt_d = pend_tgt_q;
		hit_d      = hit_q;
		toolong_d  = toolong_q;
		buf_we     = 1'b0;
		pat_we     = 1'b0;
		emit       = 1'b0;
		emit_rsp   = '{status: STAT_OK, found: 1'b0, result_target: '0, last_result: 1'b1};
		dir_cmd    = '{op: DIR_NONE, idx: e_q, plen: tl_q, ptgt: tgt_q};

		unique case (state_q)
			ST_IDLE: begin
				if (acc && req.string_byte != 8'd0) begin
					if (len_q < LEN_W'(MAX_STRING_LEN)) begin
						buf_we = 1'b1;
						len_d  = len_q + LEN_W'(1);
					end else begin
						toolong_d = 1'b1;
					end
				end else if (acc_end) begin
					len_d     = '0;
					toolong_d = 1'b0;
					tl_d      = len_q;
					mode_d    = mode_t'(req.mode);
					tgt_d     = req.bind_target;
					maxt_d    = maxt_c;
					e_d       = '0;
					n_d       = '0;
					pend_v_d  = 1'b0;
					hit_d     = 1'b0;
					if (toolong_q) begin
						emit            = 1'b1;
						emit_rsp.status = STAT_LONG;
					end else if (req.mode == MODE_ROUTE && maxt_c == '0) begin
						emit            = 1'b1;
						emit_rsp.status = STAT_NONE;
					end
				end
			end
			ST_ENTRY: begin
				if (ev_end) begin
					k_d = '0;
					case (mode_q)
						MODE_BIND: begin
							if (dir_stat.count >= CNT_W'(MAX_BINDINGS)) begin
								emit            = 1'b1;
								emit_rsp.status = STAT_FULL;
							end
						end
						MODE_UNBIND: begin
							emit            = 1'b1;
							emit_rsp.status = hit_q ? STAT_OK : STAT_NONE;
						end
						MODE_QUERY: begin
							emit            = 1'b1;
							emit_rsp.status = STAT_NONE;
						end
						default: begin
							emit = 1'b1;
							if (pend_v_q) begin
								emit_rsp.found         = 1'b1;
								emit_rsp.result_target = pend_tgt_q;
							end else begin
								emit_rsp.status = STAT_NONE;
							end
						end
					endcase
				end else if (ev_no) begin
					e_d = e_q + CNT_W'(1);
				end else begin
					k_d     = '0;
					pi_d    = '0;
					ti_d    = '0;
					sp_d    = '0;
					st_d    = '0;
					pdone_d = 1'b0;
					tdone_d = 1'b0;
					eq_d    = 1'b1;
					tfin_d  = 1'b0;
				end
			end
			ST_EQ_EV: begin
				k_d = k_q + LEN_W'(1);
				if (ev_no) begin
					e_d = e_q + CNT_W'(1);
				end
			end
			ST_MT_RD: begin
				pv_d = pv_now;
				tv_d = tv_now;
			end
			ST_MT_EV: begin
				k_d     = k_q + LEN_W'(1);
				pdone_d = pdone_n;
				tdone_d = tdone_n;
				if (!pdone_n) begin
					sp_d = sp_q + LEN_W'(1);
					if (sp_q == '0) begin
						first_d = pat_rdata;
					end
				end
				if (!tdone_n) begin
					st_d = st_q + LEN_W'(1);
				end
				if (!pdone_n && !tdone_n && pat_rdata != buf_rdata) begin
					eq_d = 1'b0;
				end
			end
			ST_SEG: begin
				if (!seg_done) begin
					pi_d    = LEN_W'(pseg_end + (LEN_W + 1)'(1));
					if (!seg_tfin) begin
						ti_d = LEN_W'(tseg_end + (LEN_W + 1)'(1));
					end
					tfin_d  = seg_tfin;
					k_d     = '0;
					sp_d    = '0;
					st_d    = '0;
					pdone_d = 1'b0;
					tdone_d = 1'b0;
					eq_d    = 1'b1;
				end else if (ev_no) begin
					e_d = e_q + CNT_W'(1);
				end
			end
			ST_CPY_RD: begin
				if (k_q == tl_q) begin
					dir_cmd.op = DIR_APPEND;
					emit       = 1'b1;
				end
			end
			ST_CPY_WR: begin
				pat_we = 1'b1;
				k_d    = k_q + LEN_W'(1);
			end
			ST_FLUSH: begin
				emit                   = 1'b1;
				emit_rsp.found         = 1'b1;
				emit_rsp.result_target = pend_tgt_q;
			end
			default: begin
			end
		endcase

		if (ev_yes) begin
			case (mode_q)
				MODE_BIND: begin
					dir_cmd.op = DIR_SET_TGT;
					emit       = 1'b1;
				end
				MODE_UNBIND: begin
					dir_cmd.op = DIR_REMOVE;
					hit_d      = 1'b1;
				end
				MODE_QUERY: begin
					emit           = 1'b1;
					emit_rsp.found = 1'b1;
				end
				default: begin
					// The previous match goes out now; the newest one waits
					// until it is known whether it is the final beat.
					if (pend_v_q) begin
						emit                   = 1'b1;
						emit_rsp.found         = 1'b1;
						emit_rsp.result_target = pend_tgt_q;
						emit_rsp.last_result   = 1'b0;
					end
					pend_v_d   = 1'b1;
					pend_tgt_d = dir_stat.ptgt;
					n_d        = n_q + MAXT_W'(1);
					e_d        = e_q + CNT_W'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			toolong_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			len_q     <= len_d;
			toolong_q <= toolong_d;
			strobe_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		tgt_q      <= tgt_d;
		maxt_q     <= maxt_d;
		n_q        <= n_d;
		tl_q       <= tl_d;
		k_q        <= k_d;
		pi_q       <= pi_d;
		ti_q       <= ti_d;
		sp_q       <= sp_d;
		st_q       <= st_d;
		e_q        <= e_d;
		pdone_q    <= pdone_d;
		tdone_q    <= tdone_d;
		eq_q       <= eq_d;
		tfin_q     <= tfin_d;
		pv_q       <= pv_d;
		tv_q       <= tv_d;
		first_q    <= first_d;
		pend_v_q   <= pend_v_d;
		pend_tgt_q <= pend_tgt_d;
		hit_q      <= hit_d;
		rsp_q      <= emit_rsp;
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	`TPRT_ASSERT_IMP(a_strobe_cause, strobe, $past(busy) || $past(start && req.string_byte == 8'd0))
	`TPRT_ASSERT_NEXT(a_data_quiet, start && !busy && req.string_byte != 8'd0, !strobe)
	`TPRT_ASSERT_IMP(a_append_room, dir_cmd.op == DIR_APPEND, dir_stat.count < CNT_W'(MAX_BINDINGS))

endmodule

FILE: design/tprt_ram.sv
// ----------------------------------------------------------------------------
// Topic router RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tprt_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/tprt_dir.sv
// ----------------------------------------------------------------------------
// Topic router directory
// Binding order as a permutation of physical slots, with length and target.
// ----------------------------------------------------------------------------
module tprt_dir import tprt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dir_cmd_t  cmd,
	output dir_stat_t stat
);

	logic [SLOT_W-1:0] order_q [MAX_BINDINGS];
	logic [LEN_W-1:0]  plen_q  [MAX_BINDINGS];
	logic [TGT_W-1:0]  ptgt_q  [MAX_BINDINGS];
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] slot;

	assign slot       = order_q[cmd.idx[SLOT_W-1:0]];
	assign stat.slot  = slot;
	assign stat.plen  = plen_q[slot];
	assign stat.ptgt  = ptgt_q[slot];
	assign stat.count = count_q;

	// A removed slot rotates to the end of the order, so the slot just past
	// the live entries is always free for the next append.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_BINDINGS; j++) begin
				order_q[j] <= SLOT_W'(j);
			end
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				DIR_REMOVE: begin
					for (int j = 0; j < MAX_BINDINGS - 1; j++) begin
						if (CNT_W'(j) >= cmd.idx) begin
							order_q[j] <= order_q[j + 1];
						end
					end
					order_q[MAX_BINDINGS - 1] <= slot;
					count_q <= count_q - CNT_W'(1);
				end
				DIR_APPEND: begin
					count_q <= count_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DIR_SET_TGT: begin
				ptgt_q[slot] <= cmd.ptgt;
			end
			DIR_APPEND: begin
				ptgt_q[slot] <= cmd.ptgt;
				plen_q[slot] <= cmd.plen;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Topic pattern router table testbench
// Feeds byte-serial bind, unbind, route and query strings with random gaps,
// predicts every result beat from a behavioral table and checks each field.
// ----------------------------------------------------------------------------
module tb;
	import tprt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	tprt_in_t  req;
	logic      strobe;
	tprt_out_t rsp;

	topic_pattern_router_table_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Predicted table contents.
	byte unsigned     tbl_str[MAX_BINDINGS][$];
	logic [TGT_W-1:0] tbl_tgt[MAX_BINDINGS];
	int               tbl_cnt = 0;
	byte unsigned     cur_str[$];
	bit               cur_long = 1'b0;

	tprt_in_t  cmd_queue[$];
	tprt_out_t result_queue[$];
	int        mismatches = 0;

	function automatic bit same_string(int e);
		if (tbl_str[e].size() != cur_str.size())
			return 0;
		foreach (cur_str[k])
			if (tbl_str[e][k] != cur_str[k])
				return 0;
		return 1;
	endfunction

	function automatic bit pattern_matches(int e);
		byte unsigned p[$];
		int pl, tl, pi, ti, sp, st;
		bit pend, tend, phash, pstar;
		p = tbl_str[e];
		pl = p.size();
		tl = cur_str.size();
		pi = 0;
		ti = 0;
		forever begin
			sp = 0;
			st = 0;
			while (pi + sp < pl && p[pi + sp] != CH_DOT) sp++;
			while (ti + st < tl && cur_str[ti + st] != CH_DOT) st++;
			pend = pi + sp >= pl;
			tend = ti + st >= tl;
			phash = sp == 1 && p[pi] == CH_HASH;
			pstar = sp == 1 && p[pi] == CH_STAR;
			if (pend && sp == 0 && tend && st == 0) return 1;
			if (phash) return pend;
			if (tend && st == 0) return 0;
			if (pend && sp == 0) return 0;
			if (!pstar) begin
				if (sp != st) return 0;
				for (int k = 0; k < sp; k++)
					if (p[pi + k] != cur_str[ti + k]) return 0;
			end
			if (pend && tend) return 1;
			if (pend) return 0;
			if (tend) begin
				pi += sp + 1;
				return pi < pl && p[pi] == CH_HASH && pi + 1 >= pl;
			end
			pi += sp + 1;
			ti += st + 1;
		end
	endfunction

	function automatic tprt_out_t mk(logic [1:0] s, logic f, logic [15:0] t, logic l);
		tprt_out_t r;
		r.status = s;
		r.found = f;
		r.result_target = t;
		r.last_result = l;
		return r;
	endfunction

	// Works out the result beats of one accepted command beat.
	task automatic predict_router(tprt_in_t c);
		int n, lim, hit, e;
		bit ok;
		if (c.string_byte != 0) begin
			if (cur_str.size() < MAX_STRING_LEN)
				cur_str.push_back(c.string_byte);
			else
				cur_long = 1;
			return;
		end
		if (cur_long) begin
			result_queue.push_back(mk(STAT_LONG, 1'b0, '0, 1'b1));
		end else begin
			case (mode_t'(c.mode))
				MODE_BIND: begin
					hit = -1;
					for (e = 0; e < tbl_cnt; e++)
						if (hit < 0 && same_string(e)) hit = e;
					if (hit >= 0) begin
						tbl_tgt[hit] = c.bind_target;
						result_queue.push_back(mk(STAT_OK, 1'b0, '0, 1'b1));
					end else if (tbl_cnt >= MAX_BINDINGS) begin
						result_queue.push_back(mk(STAT_FULL, 1'b0, '0, 1'b1));
					end else begin
						tbl_str[tbl_cnt] = cur_str;
						tbl_tgt[tbl_cnt] = c.bind_target;
						tbl_cnt++;
						result_queue.push_back(mk(STAT_OK, 1'b0, '0, 1'b1));
					end
				end
				MODE_UNBIND: begin
					ok = 0;
					e = 0;
					while (e < tbl_cnt) begin
						if (same_string(e)) begin
							for (int j = e; j + 1 < tbl_cnt; j++) begin
								tbl_str[j] = tbl_str[j + 1];
								tbl_tgt[j] = tbl_tgt[j + 1];
							end
							tbl_cnt--;
							ok = 1;
						end else begin
							e++;
						end
					end
					result_queue.push_back(mk(ok ? STAT_OK : STAT_NONE, 1'b0, '0, 1'b1));
				end
				MODE_ROUTE: begin
					lim = c.target_limit > RESULT_LIMIT ? RESULT_LIMIT : int'(c.target_limit);
					n = 0;
					for (e = 0; e < tbl_cnt && n < lim; e++)
						if (pattern_matches(e)) begin
							result_queue.push_back(mk(STAT_OK, 1'b1, tbl_tgt[e], 1'b0));
							n++;
						end
					if (n == 0)
						result_queue.push_back(mk(STAT_NONE, 1'b0, '0, 1'b1));
					else
						result_queue[$].last_result = 1'b1;
				end
				default: begin
					ok = 0;
					for (e = 0; e < tbl_cnt; e++)
						if (same_string(e)) ok = 1;
					result_queue.push_back(mk(ok ? STAT_OK : STAT_NONE, ok, '0, 1'b1));
				end
			endcase
		end
		cur_str.delete();
		cur_long = 0;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic push_string(string s, mode_t m, int tgt, int maxt);
		tprt_in_t c;
		for (int k = 0; k < s.len(); k++) begin
			c.mode = 2'($urandom_range(0, 3));
			c.string_byte = s[k];
			c.bind_target = TGT_W'($urandom);
			c.target_limit = MAXT_W'($urandom);
			cmd_queue.push_back(c);
		end
		c.mode = m;
		c.string_byte = 8'h00;
		c.bind_target = TGT_W'(tgt);
		c.target_limit = MAXT_W'(maxt);
		cmd_queue.push_back(c);
	endtask

	function automatic string rand_word(bit pat);
		string w;
		int r;
		r = $urandom_range(0, 9);
		if (pat && r == 0) return "*";
		if (pat && r == 1) return "#";
		if (r == 2) return "";
		case ($urandom_range(0, 3))
			0: w = "a";
			1: w = "b";
			2: w = "ab";
			default: w = "c";
		endcase
		return w;
	endfunction

	function automatic string rand_str(bit pat);
		string s;
		int segs;
		segs = $urandom_range(1, 4);
		s = rand_word(pat);
		for (int k = 1; k < segs; k++)
			s = {s, ".", rand_word(pat)};
		return s;
	endfunction

	// A beat is taken at a rising edge where start is high and busy is low.
	bit taken_q;
	always @(posedge clk) begin
		taken_q <= arst_n && start && !busy;
	end

	// Driver: one beat per handshake, random gaps between beats.
	int gap_cnt;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_cnt <= 0;
		end else if (start && taken_q) begin
			if (gap_cnt == 0 && cmd_queue.size() > 0 && gap_len() == 0) begin
				req <= cmd_queue.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
				gap_cnt <= gap_len();
			end
		end else if (!start) begin
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
			end else if (cmd_queue.size() > 0) begin
				req <= cmd_queue.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: predicts on accepted commands, checks each result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (result_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", rsp);
				end else begin
					tprt_out_t exp_r;
					exp_r = result_queue.pop_front();
					if (rsp !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, actual %p", exp_r, rsp);
					end
				end
			end
			if (start && !busy)
				predict_router(req);
		end
	end

	initial begin
		string long_s;
		arst_n = 1'b0;

		// Directed part.
		push_string("a.b", MODE_QUERY, 0, 0);
		push_string("", MODE_BIND, 16'hFFFF, 0);
		push_string("a.*", MODE_BIND, 16'h0001, 0);
		push_string("a.#", MODE_BIND, 16'h8000, 0);
		push_string("#", MODE_BIND, 16'h0000, 0);
		push_string("a.*", MODE_BIND, 16'h1234, 0);
		push_string("a.b", MODE_ROUTE, 0, 16);
		push_string("a", MODE_ROUTE, 0, 31);
		push_string("a.", MODE_ROUTE, 0, 2);
		push_string("a.b", MODE_ROUTE, 0, 0);
		// Twelve new patterns fill the table and the last bind finds it full.
		for (int k = 0; k < MAX_BINDINGS - 3; k++)
			push_string($sformatf("%c", 8'h63 + k), MODE_BIND, k, 0);
		push_string("*", MODE_ROUTE, 0, 20);
		push_string("c", MODE_ROUTE, 0, 1);
		push_string("a.*", MODE_UNBIND, 0, 0);
		long_s = "";
		for (int k = 0; k < MAX_STRING_LEN + 1; k++) long_s = {long_s, "x"};
		push_string(long_s, MODE_ROUTE, 0, 3);

		// Random well-formed commands, plus some raw byte noise.
		while (cmd_queue.size() < 140) begin
			if ($urandom_range(0, 9) == 0) begin
				tprt_in_t c;
				c.mode = 2'($urandom);
				c.string_byte = 8'($urandom);
				c.bind_target = TGT_W'($urandom);
				c.target_limit = MAXT_W'($urandom);
				cmd_queue.push_back(c);
			end else begin
				int m;
				m = $urandom_range(0, 9);
				if (m < 4)
					push_string(rand_str(1), MODE_BIND, $urandom, $urandom);
				else if (m < 6)
					push_string(rand_str(1), MODE_UNBIND, $urandom, $urandom);
				else if (m < 8)
					push_string(rand_str(0), MODE_ROUTE, $urandom, $urandom_range(0, 31));
				else
					push_string(rand_str(1), MODE_QUERY, $urandom, $urandom);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (cmd_queue.size() == 0);
		@(posedge clk);
		while (start) @(posedge clk);
		wait (result_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && result_queue.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: topic_pattern_router_table_top.f
+incdir+design
design/tprt_pkg.sv
design/tprt_ram.sv
design/tprt_dir.sv
design/topic_pattern_router_table_top.sv
tb/tb.sv
